### rtl/sirs_pkg.sv
// ============================================================================
// sirs_pkg: shared types and constants for the radix symbol converter
// Widths, register codes, reset values, controller states and the command
// and status words between the controller and the datapath.
// ============================================================================
package sirs_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int MAX_SYMBOLS = 16;

    localparam int LEN_W     = 5;
    localparam int SYM_W     = 8;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;

    localparam int DIGIT_W    = $clog2(MAX_SYMBOLS);
    localparam int REM_W      = DIGIT_W + 1;
    localparam int STEP_BITS  = 4;
    localparam int DIV_STEPS  = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int WORK_W     = DIV_STEPS * STEP_BITS;
    localparam int STEP_CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
    localparam int MAX_DIGITS = VALUE_BITS;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int STK_W      = $clog2(MAX_DIGITS);

    localparam logic [LEN_W-1:0] RST_ALPHABET_LENGTH = 5'd10;
    localparam logic [CFG_W-1:0] RST_SYMBOLS_LOW     = 64'h3736_3534_3332_3130;
    localparam logic [CFG_W-1:0] RST_SYMBOLS_HIGH    = 64'h0000_0000_0000_3938;

    localparam logic [SYM_W-1:0] MINUS_SYMBOL = 8'h2D;
    localparam logic [SYM_W-1:0] PLUS_SYMBOL  = 8'h2B;
    localparam logic [LEN_W-1:0] MIN_RADIX    = 5'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHABET_LENGTH = 2'd0,
        CFG_SYMBOLS_LOW     = 2'd1,
        CFG_SYMBOLS_HIGH    = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_PUSH,
        ST_SIGN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic push;
        logic emit_sign;
        logic emit_digit;
    } cmd_t;

    typedef struct packed {
        logic alpha_ok;
        logic neg;
        logic div_last;
        logic q_zero;
        logic cnt_last;
        logic out_free;
    } stat_t;

endpackage

### rtl/sirs_ctrl.sv
// ============================================================================
// sirs_ctrl: sequencing controller
// Accepts a word, checks the alphabet and drops the word if it is invalid,
// else runs the digit division loop, then emits any minus sign and the stacked digits.
// ============================================================================
module sirs_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  sirs_pkg::stat_t stat,
    output sirs_pkg::cmd_t  cmd
);

    sirs_pkg::state_t state_reg;
    sirs_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sirs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            sirs_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sirs_pkg::ST_CHECK;
                end
            end
            sirs_pkg::ST_CHECK:
            begin
                state_next = stat.alpha_ok ? sirs_pkg::ST_DIVIDE : sirs_pkg::ST_IDLE;
            end
            sirs_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = sirs_pkg::ST_PUSH;
                end
            end
            sirs_pkg::ST_PUSH:
            begin
                cmd.push = 1'b1;
                if (!stat.q_zero)
                begin
                    state_next = sirs_pkg::ST_DIVIDE;
                end
                else if (stat.neg)
                begin
                    state_next = sirs_pkg::ST_SIGN;
                end
                else
                begin
                    state_next = sirs_pkg::ST_EMIT;
                end
            end
            sirs_pkg::ST_SIGN:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = sirs_pkg::ST_EMIT;
                end
            end
            sirs_pkg::ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (stat.cnt_last)
                    begin
                        state_next = sirs_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sirs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/sirs_dp.sv
// ============================================================================
// sirs_dp: conversion datapath
// Configuration registers, alphabet check, remainder unit working four
// quotient bits a cycle, digit stack and output register.
// ============================================================================
module sirs_dp
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [sirs_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [sirs_pkg::CFG_W-1:0]             cfg_data,
    input  logic signed [sirs_pkg::VALUE_BITS-1:0] value,
    input  sirs_pkg::cmd_t                         cmd,
    output sirs_pkg::stat_t                        stat,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [sirs_pkg::SYM_W-1:0]             symbol,
    output logic                                   last
);

    logic [sirs_pkg::LEN_W-1:0]      len_reg;
    logic [sirs_pkg::CFG_W-1:0]      sym_lo_reg;
    logic [sirs_pkg::CFG_W-1:0]      sym_hi_reg;

    logic [sirs_pkg::SYM_W-1:0]      sym_tab [sirs_pkg::MAX_SYMBOLS];
    logic                            alpha_ok;

    logic [sirs_pkg::VALUE_BITS-1:0] v_u;
    logic [sirs_pkg::VALUE_BITS-1:0] mag;

    logic                            neg_reg;
    logic [sirs_pkg::WORK_W-1:0]     q_reg;
    logic [sirs_pkg::WORK_W-1:0]     q_next;
    logic [sirs_pkg::DIGIT_W-1:0]    rem_reg;
    logic [sirs_pkg::DIGIT_W-1:0]    rem_next;
    logic [sirs_pkg::STEP_CNT_W-1:0] step_reg;

    logic [sirs_pkg::DIGIT_W-1:0]    stack_reg [sirs_pkg::MAX_DIGITS];
    logic [sirs_pkg::CNT_W-1:0]      cnt_reg;
    logic [sirs_pkg::STK_W-1:0]      pop_idx;
    logic                            cnt_last;

    logic                            out_valid_reg;
    logic [sirs_pkg::SYM_W-1:0]      symbol_reg;
    logic                            last_reg;
    logic                            out_free;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= sirs_pkg::RST_ALPHABET_LENGTH;
            sym_lo_reg <= sirs_pkg::RST_SYMBOLS_LOW;
            sym_hi_reg <= sirs_pkg::RST_SYMBOLS_HIGH;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sirs_pkg::CFG_ALPHABET_LENGTH: len_reg    <= cfg_data[sirs_pkg::LEN_W-1:0];
                sirs_pkg::CFG_SYMBOLS_LOW:     sym_lo_reg <= cfg_data;
                sirs_pkg::CFG_SYMBOLS_HIGH:    sym_hi_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        for (int k = 0; k < sirs_pkg::MAX_SYMBOLS; k++)
        begin
            if (k < 8)
            begin
                sym_tab[k] = sym_lo_reg[8*(k%8) +: 8];
            end
            else
            begin
                sym_tab[k] = sym_hi_reg[8*(k%8) +: 8];
            end
        end
    end

    // alphabet check: radix range, reserved signs, duplicates in use
    always_comb
    begin
        alpha_ok = (len_reg >= sirs_pkg::MIN_RADIX)
                && (len_reg <= sirs_pkg::LEN_W'(sirs_pkg::MAX_SYMBOLS));
        for (int a = 0; a < sirs_pkg::MAX_SYMBOLS; a++)
        begin
            if (sirs_pkg::LEN_W'(a) < len_reg)
            begin
                if (sym_tab[a] == sirs_pkg::MINUS_SYMBOL || sym_tab[a] == sirs_pkg::PLUS_SYMBOL)
                begin
                    alpha_ok = 1'b0;
                end
                for (int b = a + 1; b < sirs_pkg::MAX_SYMBOLS; b++)
                begin
                    if (sirs_pkg::LEN_W'(b) < len_reg && sym_tab[b] == sym_tab[a])
                    begin
                        alpha_ok = 1'b0;
                    end
                end
            end
        end
    end

    // magnitude
    assign v_u = value;
    assign mag = v_u[sirs_pkg::VALUE_BITS-1] ? (~v_u + sirs_pkg::VALUE_BITS'(1)) : v_u;

    // restoring remainder steps, STEP_BITS quotient bits a cycle
    always_comb
    begin
        logic [sirs_pkg::REM_W-1:0] t;
        logic                       ge;
        q_next   = q_reg;
        rem_next = rem_reg;
        for (int i = 0; i < sirs_pkg::STEP_BITS; i++)
        begin
            t  = {rem_next, q_next[sirs_pkg::WORK_W-1]};
            ge = (sirs_pkg::LEN_W'(t) >= len_reg);
            if (ge)
            begin
                t = t - sirs_pkg::REM_W'(len_reg);
            end
            rem_next = t[sirs_pkg::DIGIT_W-1:0];
            q_next   = {q_next[sirs_pkg::WORK_W-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            neg_reg <= v_u[sirs_pkg::VALUE_BITS-1];
            q_reg   <= sirs_pkg::WORK_W'(mag);
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
        else if (cmd.push)
        begin
            rem_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            stack_reg[cnt_reg[sirs_pkg::STK_W-1:0]] <= rem_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (cmd.load || cmd.push)
            begin
                step_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                step_reg <= step_reg + sirs_pkg::STEP_CNT_W'(1);
            end

            if (cmd.load)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.push)
            begin
                cnt_reg <= cnt_reg + sirs_pkg::CNT_W'(1);
            end
            else if (cmd.emit_digit)
            begin
                cnt_reg <= cnt_reg - sirs_pkg::CNT_W'(1);
            end
        end
    end

    assign pop_idx  = sirs_pkg::STK_W'(cnt_reg - sirs_pkg::CNT_W'(1));
    assign cnt_last = (cnt_reg == sirs_pkg::CNT_W'(1));

    // output register
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_sign || cmd.emit_digit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_sign)
        begin
            symbol_reg <= sirs_pkg::MINUS_SYMBOL;
            last_reg   <= 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            symbol_reg <= sym_tab[stack_reg[pop_idx]];
            last_reg   <= cnt_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign symbol    = symbol_reg;
    assign last      = last_reg;

    assign stat.alpha_ok = alpha_ok;
    assign stat.neg      = neg_reg;
    assign stat.div_last = (step_reg == sirs_pkg::STEP_CNT_W'(sirs_pkg::DIV_STEPS - 1));
    assign stat.q_zero   = (q_reg == '0);
    assign stat.cnt_last = cnt_last;
    assign stat.out_free = out_free;

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_digit |-> (cnt_reg != '0))
        else $error("digit popped from empty stack");

    a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_sign || cmd.emit_digit) |-> out_free)
        else $error("output register overwritten while held");

    a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_digit && cnt_last) |=> (out_valid_reg && last_reg))
        else $error("final digit not marked last");
`endif

endmodule

### rtl/signed_int_to_radix_symbols.sv
// ============================================================================
// signed_int_to_radix_symbols: signed integer to radix symbol run
// Converts one signed word to its digits in the configured alphabet.
// ============================================================================
// Each accepted word first has its alphabet checked. For each digit the
// remainder unit then works through the 32-bit magnitude four quotient bits
// at a time and stacks the digit. The symbols are then emitted, one per
// cycle while the output is taken. A word with an invalid alphabet produces
// no output and frees the input again. One word is in flight at a time.
module signed_int_to_radix_symbols
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [sirs_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [sirs_pkg::CFG_W-1:0]             cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [sirs_pkg::VALUE_BITS-1:0] value,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [sirs_pkg::SYM_W-1:0]             symbol,
    output logic                                   last
);

    sirs_pkg::cmd_t  cmd;
    sirs_pkg::stat_t stat;

    sirs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sirs_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .value     (value),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .symbol    (symbol),
        .last      (last)
    );

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for signed_int_to_radix_symbols
// Drives signed words through the valid/ready input and predicts each symbol
// run from a shadow copy of the alphabet registers. It covers decimal after
// reset, radix 2 and 16, alphabets that must be rejected, unused symbol
// slots, an unmapped register index, and random alphabets with random words.
// Random stalls are applied on both channels, with one stretch run flat out.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int LATENCY_GUARD = 340;
    localparam int GAP_PERCENT   = 6;
    localparam int BATCH_WORDS   = 42;
    localparam logic [sirs_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
    localparam logic [sirs_pkg::LEN_W-1:0]     LEN_MAX      = '1;

    typedef struct packed {
        logic [sirs_pkg::SYM_W-1:0] sym;
        logic                       fin;
    } glyph_t;

    logic                                   clk;
    logic                                   rst_n;
    logic                                   cfg_we;
    logic [sirs_pkg::CFG_IDX_W-1:0]         cfg_index;
    logic [sirs_pkg::CFG_W-1:0]             cfg_data;
    logic                                   in_valid;
    logic                                   in_ready;
    logic signed [sirs_pkg::VALUE_BITS-1:0] value;
    logic                                   out_valid;
    logic                                   out_ready;
    logic [sirs_pkg::SYM_W-1:0]             symbol;
    logic                                   last;

    logic [sirs_pkg::LEN_W-1:0] alpha_len;
    logic [sirs_pkg::CFG_W-1:0] alpha_lo;
    logic [sirs_pkg::CFG_W-1:0] alpha_hi;
    glyph_t                     pending_glyphs[$];
    glyph_t                     head_glyph;
    int                         mismatch_count;
    int                         cycle_count;
    bit                         gaps_on;

    signed_int_to_radix_symbols dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .symbol    (symbol),
        .last      (last)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= !gaps_on || ($urandom_range(99) >= GAP_PERCENT);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic logic [sirs_pkg::SYM_W-1:0] glyph_of(input int k);
        if (k < 8)
            return alpha_lo[8*k +: 8];
        return alpha_hi[8*(k-8) +: 8];
    endfunction

    function automatic bit alphabet_usable();
        logic [sirs_pkg::SYM_W-1:0] s;
        if (alpha_len < sirs_pkg::MIN_RADIX || alpha_len > sirs_pkg::MAX_SYMBOLS)
            return 0;
        for (int a = 0; a < alpha_len; a++)
        begin
            s = glyph_of(a);
            if (s == sirs_pkg::MINUS_SYMBOL || s == sirs_pkg::PLUS_SYMBOL)
                return 0;
            for (int b = a + 1; b < alpha_len; b++)
                if (glyph_of(b) == s)
                    return 0;
        end
        return 1;
    endfunction

    task automatic predict_run(input logic [sirs_pkg::VALUE_BITS-1:0] word);
        logic [sirs_pkg::VALUE_BITS-1:0] mag;
        logic [sirs_pkg::VALUE_BITS-1:0] radix;
        logic [sirs_pkg::DIGIT_W-1:0]    digs [sirs_pkg::MAX_DIGITS];
        int                              nd;
        if (!alphabet_usable())
            return;
        radix = sirs_pkg::VALUE_BITS'(alpha_len);
        mag   = word[sirs_pkg::VALUE_BITS-1] ? (~word + 1'b1) : word;
        nd    = 0;
        do
        begin
            digs[nd] = sirs_pkg::DIGIT_W'(mag % radix);
            nd++;
            mag = mag / radix;
        end
        while (mag != 0);
        if (word[sirs_pkg::VALUE_BITS-1])
            pending_glyphs.push_back(glyph_t'{sirs_pkg::MINUS_SYMBOL, 1'b0});
        for (int k = nd - 1; k >= 0; k--)
            pending_glyphs.push_back(glyph_t'{glyph_of(digs[k]), k == 0});
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_glyphs.size() == 0)
                report_mismatch($sformatf("unexpected symbol 0x%02h last %0b", symbol, last));
            else
            begin
                head_glyph = pending_glyphs.pop_front();
                if (symbol !== head_glyph.sym)
                    report_mismatch($sformatf("symbol 0x%02h, want 0x%02h",
                                              symbol, head_glyph.sym));
                if (last !== head_glyph.fin)
                    report_mismatch($sformatf("last %0b, want %0b on symbol 0x%02h",
                                              last, head_glyph.fin, head_glyph.sym));
            end
        end
    end

    task automatic send_word(input logic [sirs_pkg::VALUE_BITS-1:0] word);
        while (gaps_on && $urandom_range(99) < GAP_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= word;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_run(word);
    endtask

    // hold off until the block has drained and gone quiet
    task automatic drain_and_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_glyphs.size() != 0)
            @(posedge clk);
        repeat (LATENCY_GUARD) @(posedge clk);
    endtask

    task automatic write_reg(input logic [sirs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sirs_pkg::CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            sirs_pkg::CFG_ALPHABET_LENGTH: alpha_len = data[sirs_pkg::LEN_W-1:0];
            sirs_pkg::CFG_SYMBOLS_LOW:     alpha_lo  = data;
            sirs_pkg::CFG_SYMBOLS_HIGH:    alpha_hi  = data;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_alphabet(input logic [sirs_pkg::LEN_W-1:0] len,
                                  input logic [sirs_pkg::CFG_W-1:0] lo,
                                  input logic [sirs_pkg::CFG_W-1:0] hi);
        write_reg(sirs_pkg::CFG_ALPHABET_LENGTH, {32'($urandom), 27'($urandom), len});
        write_reg(sirs_pkg::CFG_SYMBOLS_LOW, lo);
        write_reg(sirs_pkg::CFG_SYMBOLS_HIGH, hi);
    endtask

    function automatic logic [sirs_pkg::VALUE_BITS-1:0] random_word();
        logic [sirs_pkg::VALUE_BITS-1:0] m;
        case ($urandom_range(9))
            5, 6:
            begin
                m = $urandom_range(255);
                return $urandom_range(1) ? -m : m;
            end
            7: return 32'h8000_0000 + $urandom_range(3);
            8: return 32'h7FFF_FFFF - $urandom_range(3);
            9:
            begin
                m = $urandom >> $urandom_range(31);
                return $urandom_range(1) ? -m : m;
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic load_random_alphabet(input bit usable);
        logic [sirs_pkg::SYM_W-1:0] syms [sirs_pkg::MAX_SYMBOLS];
        logic [sirs_pkg::CFG_W-1:0] lo;
        logic [sirs_pkg::CFG_W-1:0] hi;
        int                         n;
        int                         a;
        int                         b;
        bit                         clash;
        n = $urandom_range(sirs_pkg::MIN_RADIX, sirs_pkg::MAX_SYMBOLS);
        for (int k = 0; k < sirs_pkg::MAX_SYMBOLS; k++)
        begin
            do
            begin
                syms[k] = sirs_pkg::SYM_W'($urandom);
                clash = (k < n) && (syms[k] == sirs_pkg::PLUS_SYMBOL
                                    || syms[k] == sirs_pkg::MINUS_SYMBOL);
                for (int j = 0; j < k && k < n; j++)
                    if (syms[j] == syms[k])
                        clash = 1;
            end
            while (clash);
        end
        if (!usable)
        begin
            case ($urandom_range(3))
                0: n = $urandom_range(sirs_pkg::MIN_RADIX - 1);
                1: n = $urandom_range(sirs_pkg::MAX_SYMBOLS + 1, LEN_MAX);
                2:
                begin
                    a = $urandom_range(n - 2);
                    b = $urandom_range(a + 1, n - 1);
                    syms[b] = syms[a];
                end
                default: syms[$urandom_range(n - 1)] =
                             $urandom_range(1) ? sirs_pkg::PLUS_SYMBOL
                                               : sirs_pkg::MINUS_SYMBOL;
            endcase
        end
        for (int k = 0; k < sirs_pkg::MAX_SYMBOLS; k++)
        begin
            if (k < 8)
                lo[8*k +: 8] = syms[k];
            else
                hi[8*(k-8) +: 8] = syms[k];
        end
        write_alphabet(sirs_pkg::LEN_W'(n), lo, hi);
    endtask

    task automatic send_batch(input int count);
        for (int i = 0; i < count; i++)
            send_word(random_word());
    endtask

    task automatic test_default_decimal();
        send_word(32'd0);
        send_word(32'hFFFF_FFFF);
        send_word(32'd10);
        send_word(32'd9);
        send_word(32'h7FFF_FFFF);
        send_word(32'h8000_0000);
    endtask

    task automatic test_radix_extremes();
        drain_and_idle();
        write_alphabet(sirs_pkg::MIN_RADIX, 64'h0000_0000_0000_3130, 64'h0);
        send_word(32'h7FFF_FFFF);
        send_word(32'h8000_0000);
        send_word(32'd0);
        drain_and_idle();
        write_alphabet(sirs_pkg::LEN_W'(sirs_pkg::MAX_SYMBOLS), 64'h3736_3534_3332_3100,
                       64'hFF45_4443_4241_3938);
        send_word(32'h8000_0000);
        send_word(32'hFFFF_FFFF);
        send_word(32'hDEAD_BEEF);
        send_word(32'h7FFF_FFFF);
    endtask

    task automatic test_bad_alphabets();
        drain_and_idle();
        write_alphabet(5'd0, sirs_pkg::RST_SYMBOLS_LOW, sirs_pkg::RST_SYMBOLS_HIGH);
        send_word(32'd42);
        drain_and_idle();
        write_alphabet(5'd1, sirs_pkg::RST_SYMBOLS_LOW, sirs_pkg::RST_SYMBOLS_HIGH);
        send_word(32'hFFFF_FFD6);
        drain_and_idle();
        write_alphabet(sirs_pkg::LEN_W'(sirs_pkg::MAX_SYMBOLS + 1), sirs_pkg::RST_SYMBOLS_LOW,
                       64'h5251_5045_4443_4241);
        send_word(32'h8000_0000);
        drain_and_idle();
        write_alphabet(LEN_MAX, sirs_pkg::RST_SYMBOLS_LOW, sirs_pkg::RST_SYMBOLS_HIGH);
        send_word(32'h7FFF_FFFF);
        drain_and_idle();
        write_alphabet(5'd10, 64'h3736_3534_3732_3130, sirs_pkg::RST_SYMBOLS_HIGH);
        send_word(32'd1234);
        drain_and_idle();
        write_alphabet(5'd12, sirs_pkg::RST_SYMBOLS_LOW, 64'h0000_0000_4241_2B38);
        send_word(32'd99);
        drain_and_idle();
        write_alphabet(sirs_pkg::LEN_W'(sirs_pkg::MAX_SYMBOLS), sirs_pkg::RST_SYMBOLS_LOW,
                       64'h2D45_4443_4241_3938);
        send_word(32'hFFFF_FF00);
    endtask

    task automatic test_unused_slots();
        drain_and_idle();
        write_alphabet(5'd3, 64'h2D2B_6161_2D63_6261, 64'h2B2D_2B2D_2B2D_2B2D);
        send_word(32'hFFFF_FFF9);
        send_word(32'd100);
        drain_and_idle();
        write_reg(CFG_UNMAPPED, {32'($urandom), 32'($urandom)});
        send_word(32'd5);
    endtask

    task automatic test_random_alphabets();
        for (int phase = 0; phase < 11; phase++)
        begin
            drain_and_idle();
            if (phase == 3 || phase == 7)
            begin
                load_random_alphabet(1'b0);
                send_batch(6);
            end
            else
            begin
                load_random_alphabet(1'b1);
                send_batch(BATCH_WORDS);
            end
        end
    endtask

    task automatic test_back_to_back();
        drain_and_idle();
        gaps_on <= 1'b0;
        load_random_alphabet(1'b1);
        send_batch(BATCH_WORDS);
        gaps_on <= 1'b1;
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = sirs_pkg::CFG_ALPHABET_LENGTH;
        cfg_data       = '0;
        in_valid       = 1'b0;
        value          = '0;
        out_ready      = 1'b0;
        gaps_on        = 1'b1;
        mismatch_count = 0;
        cycle_count    = 0;
        alpha_len      = sirs_pkg::RST_ALPHABET_LENGTH;
        alpha_lo       = sirs_pkg::RST_SYMBOLS_LOW;
        alpha_hi       = sirs_pkg::RST_SYMBOLS_HIGH;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_decimal();
        test_radix_extremes();
        test_bad_alphabets();
        test_unused_slots();
        test_random_alphabets();
        test_back_to_back();
        drain_and_idle();

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

### filelist.f
rtl/sirs_pkg.sv
rtl/sirs_ctrl.sv
rtl/sirs_dp.sv
rtl/signed_int_to_radix_symbols.sv
sim/tb.sv
